@@ src/scc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the short and continuity check
// Hole, edge and cell state types, codes and sizes used by the chain of cells
// and by the top level controller.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int MAX_EDGES   = 64;
   // a walk ends after this many clean visits at the head of the ring
   localparam int QUIET_LIMIT = 2 * MAX_EDGES;
   localparam int QUIET_W     = $clog2(QUIET_LIMIT);

   localparam int X_W     = 5;
   localparam int Y_W     = 4;
   localparam int KIND_W  = 2;
   localparam int CODE_W  = 2;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 4;

   localparam logic [KIND_W-1:0] KIND_RESISTOR  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_CAPACITOR = KIND_W'(2);

   localparam logic [CODE_W-1:0] ERR_NONE          = CODE_W'(0);
   localparam logic [CODE_W-1:0] ERR_NO_SUPPLY     = CODE_W'(1);
   localparam logic [CODE_W-1:0] ERR_SHORT         = CODE_W'(2);
   localparam logic [CODE_W-1:0] ERR_NO_CONDUCTION = CODE_W'(3);

   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_ROW = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND_ROW = CSR_IDX_W'(1);

   localparam logic [Y_W-1:0] SUPPLY_ROW_RESET = Y_W'(1);
   localparam logic [Y_W-1:0] GROUND_ROW_RESET = Y_W'(12);

   typedef struct packed {
      logic [Y_W-1:0] y;
      logic [X_W-1:0] x;
   } hole_type;

   typedef struct packed {
      hole_type          a;
      hole_type          b;
      logic [KIND_W-1:0] kind;
   } edge_type;

   // beat travelling down the chain while a list loads
   typedef struct packed {
      logic     has_edge;
      logic     last;
      edge_type edge_data;
   } load_tok_type;

   typedef struct packed {
      logic     occupied;
      edge_type edge_data;
      logic     reach_a;
      logic     reach_b;
      logic     dirty;
   } cell_state_type;

   // reached holes of the ring head, seen by every cell
   typedef struct packed {
      logic     a_valid;
      hole_type a;
      logic     b_valid;
      hole_type b;
   } bcast_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_INIT,
      CELL_ROTATE,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type    op;
      logic           wires_only;
      logic [Y_W-1:0] supply_row;
   } cell_ctl_type;

   function automatic logic is_wire_like(logic [KIND_W-1:0] kind);
      return (kind != KIND_RESISTOR) && (kind != KIND_CAPACITOR);
   endfunction

endpackage

@@ src/scc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_if: channel interfaces of the short and continuity check
// Edge request channel, error code response channel and register write port.
// ----------------------------------------------------------------------------
interface scc_req_if
   import scc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [X_W-1:0]    end1_x;
   logic [Y_W-1:0]    end1_y;
   logic [X_W-1:0]    end2_x;
   logic [Y_W-1:0]    end2_y;
   logic [KIND_W-1:0] part_kind;
   logic              last_edge;

   modport source (output valid, end1_x, end1_y, end2_x, end2_y, part_kind, last_edge,
                   input ready);
   modport sink (input valid, end1_x, end1_y, end2_x, end2_y, part_kind, last_edge,
                 output ready);
endinterface

interface scc_rsp_if
   import scc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] error_code;

   modport source (output valid, error_code, input ready);
   modport sink (input valid, error_code, output ready);
endinterface

interface scc_csr_if
   import scc_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/circuit_short_and_continuity_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circuit_short_and_continuity_check: board short and continuity check
// Stores the edges of one list in a chain of cells, then walks the chain as a
// ring to find what the supply row reaches, and returns one error code.
// ----------------------------------------------------------------------------
// Edges are taken one beat per cycle while a list loads; each beat travels
// down the chain of MAX_EDGES cells, where a free cell stores it and a cell
// holding the same two ends drops it. After the beat with last_edge set the
// block stops taking edges: the chain drains, then up to two walks run, each
// one init step plus ring rotations. A walk ends once the cell at the ring
// head stops bringing new marks, as counted by the quiet counter. The error
// code goes to an output register, and edges of the next list are taken
// while that code waits to be taken.
// ----------------------------------------------------------------------------
module circuit_short_and_continuity_check
   import scc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   scc_req_if.sink    req_ch,
   scc_rsp_if.source  rsp_ch,
   scc_csr_if.sink    csr_ch
);

   typedef enum logic [5:0] {
      ST_LOAD   = 6'b000001,
      ST_DRAIN  = 6'b000010,
      ST_INIT   = 6'b000100,
      ST_WALK   = 6'b001000,
      ST_SETTLE = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [Y_W-1:0]    supply_row_ff, ground_row_ff;
   logic              walk_all_ff, walk_all_in;
   logic              found_ff, found_in;
   logic              seed_ff, seed_in;
   logic [QUIET_W-1:0] quiet_ff, quiet_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;

   logic           req_accept;
   cell_ctl_type   cell_ctl;
   bcast_type      bcast;
   cell_state_type head, head_clean;
   load_tok_type   tok [MAX_EDGES+1];
   cell_state_type cell_st [MAX_EDGES];
   cell_state_type rot_src [MAX_EDGES];

   // register write port
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_row_ff <= SUPPLY_ROW_RESET;
         ground_row_ff <= GROUND_ROW_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_SUPPLY_ROW: supply_row_ff <= Y_W'(csr_ch.data);
            CSR_GROUND_ROW: ground_row_ff <= Y_W'(csr_ch.data);
            default: begin
            end
         endcase
      end
   end

   // edge beats enter the chain at cell 0
   assign req_ch.ready = (state_ff == ST_LOAD);
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      tok[0].has_edge         = req_accept;
      tok[0].last             = req_accept && req_ch.last_edge;
      tok[0].edge_data.a.x    = req_ch.end1_x;
      tok[0].edge_data.a.y    = req_ch.end1_y;
      tok[0].edge_data.b.x    = req_ch.end2_x;
      tok[0].edge_data.b.y    = req_ch.end2_y;
      tok[0].edge_data.kind   = req_ch.part_kind;
   end

   assign head = cell_st[MAX_EDGES-1];

   // the head's content wraps to cell 0 with its visit recorded
   always_comb begin
      head_clean       = head;
      head_clean.dirty = 1'b0;
   end

   always_comb begin
      bcast.a_valid = (state_ff == ST_WALK) && head.reach_a;
      bcast.a       = head.edge_data.a;
      bcast.b_valid = (state_ff == ST_WALK) && head.reach_b;
      bcast.b       = head.edge_data.b;
   end

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      if (i == 0) begin : g_wrap
         assign rot_src[i] = head_clean;
      end else begin : g_link
         assign rot_src[i] = cell_st[i-1];
      end

      scc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .ld_in     (tok[i]),
         .rot_in    (rot_src[i]),
         .bcast     (bcast),
         .ld_out    (tok[i+1]),
         .state_out (cell_st[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      walk_all_in  = walk_all_ff;
      found_in     = found_ff;
      seed_in      = seed_ff;
      quiet_in     = quiet_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_code_in  = rsp_code_ff;

      cell_ctl.op         = CELL_HOLD;
      cell_ctl.wires_only = !walk_all_ff;
      cell_ctl.supply_row = supply_row_ff;

      unique case (state_ff)
         ST_LOAD: begin
            cell_ctl.op = CELL_LOAD;
            if (req_accept && req_ch.last_edge) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cell_ctl.op = CELL_LOAD;
            if (tok[MAX_EDGES].last) begin
               walk_all_in = 1'b0;
               state_in    = ST_INIT;
            end
         end
         ST_INIT: begin
            cell_ctl.op = CELL_INIT;
            found_in    = 1'b0;
            seed_in     = 1'b0;
            quiet_in    = '0;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            cell_ctl.op = CELL_ROTATE;
            found_in = found_ff ||
                       (head.reach_a && (head.edge_data.a.y == ground_row_ff)) ||
                       (head.reach_b && (head.edge_data.b.y == ground_row_ff));
            seed_in  = seed_ff || (head.occupied &&
                       ((head.edge_data.a.y == supply_row_ff) ||
                        (head.edge_data.b.y == supply_row_ff)));
            if (head.dirty) begin
               quiet_in = '0;
            end else if (quiet_ff == QUIET_W'(QUIET_LIMIT - 1)) begin
               state_in = ST_SETTLE;
            end else begin
               quiet_in = quiet_ff + QUIET_W'(1);
            end
         end
         ST_SETTLE: begin
            if (walk_all_ff) begin
               code_in  = found_ff ? ERR_NONE : ERR_NO_CONDUCTION;
               state_in = ST_RESULT;
            end else if (!seed_ff) begin
               code_in  = ERR_NO_SUPPLY;
               state_in = ST_RESULT;
            end else if (found_ff) begin
               code_in  = ERR_SHORT;
               state_in = ST_RESULT;
            end else begin
               walk_all_in = 1'b1;
               state_in    = ST_INIT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               cell_ctl.op  = CELL_CLEAR;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         walk_all_ff  <= 1'b0;
         found_ff     <= 1'b0;
         seed_ff      <= 1'b0;
         quiet_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_all_ff  <= walk_all_in;
         found_ff     <= found_in;
         seed_ff      <= seed_in;
         quiet_ff     <= quiet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.error_code = rsp_code_ff;

   // a new code only comes out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ch.ready)) |-> (state_ff == ST_RESULT))
      else $error("response loaded outside the result state");

   // the chain is empty when a new list starts
   a_chain_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESULT) && (state_in == ST_LOAD)) |=> !head.occupied && !cell_st[0].occupied)
      else $error("edge cells not cleared after a result");

   // ground can be reached only from a seed
   a_found_needs_seed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETTLE && found_ff) |-> seed_ff)
      else $error("ground reached without any supply seed");

endmodule

@@ src/scc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_cell: one edge cell of the check chain
// Holds one stored edge and its reached-end marks. While loading it takes the
// first free edge beat or drops a repeat; while walking it takes its
// neighbor's content and marks it against the holes of the ring head.
// ----------------------------------------------------------------------------
module scc_cell
   import scc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  load_tok_type   ld_in,
   input  cell_state_type rot_in,
   input  bcast_type      bcast,
   output load_tok_type   ld_out,
   output cell_state_type state_out
);

   cell_state_type state_ff, state_in;
   load_tok_type   tok_ff, tok_in;

   logic     trav;
   logic     seed_a, seed_b;
   logic     hit;
   edge_type cand;

   always_comb begin
      state_in = state_ff;
      tok_in   = '0;
      cand     = (ctl.op == CELL_ROTATE) ? rot_in.edge_data : state_ff.edge_data;
      trav     = is_wire_like(cand.kind) || !ctl.wires_only;
      seed_a   = (cand.a.y == ctl.supply_row);
      seed_b   = (cand.b.y == ctl.supply_row);
      hit      = (bcast.a_valid && ((cand.a == bcast.a) || (cand.b == bcast.a))) ||
                 (bcast.b_valid && ((cand.a == bcast.b) || (cand.b == bcast.b)));
      unique case (ctl.op)
         CELL_LOAD: begin
            tok_in = ld_in;
            if (ld_in.has_edge) begin
               if (!state_ff.occupied) begin
                  state_in.occupied  = 1'b1;
                  state_in.edge_data = ld_in.edge_data;
                  state_in.reach_a   = 1'b0;
                  state_in.reach_b   = 1'b0;
                  state_in.dirty     = 1'b0;
                  tok_in.has_edge    = 1'b0;
               end else if ((state_ff.edge_data.a == ld_in.edge_data.a) &&
                            (state_ff.edge_data.b == ld_in.edge_data.b)) begin
                  // repeat of a stored edge: the first one's kind counts
                  tok_in.has_edge = 1'b0;
               end
            end
         end
         CELL_INIT: begin
            // a seed reaches only its far end
            state_in.reach_a = state_ff.occupied && trav && !seed_a && seed_b;
            state_in.reach_b = state_ff.occupied && trav && seed_a;
            state_in.dirty   = state_in.reach_a || state_in.reach_b;
         end
         CELL_ROTATE: begin
            state_in = rot_in;
            if (rot_in.occupied && trav && !seed_a && !seed_b && hit &&
                !(rot_in.reach_a && rot_in.reach_b)) begin
               state_in.reach_a = 1'b1;
               state_in.reach_b = 1'b1;
               state_in.dirty   = 1'b1;
            end
         end
         CELL_CLEAR: begin
            state_in.occupied = 1'b0;
            state_in.reach_a  = 1'b0;
            state_in.reach_b  = 1'b0;
            state_in.dirty    = 1'b0;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         tok_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in;
      end
   end

   assign ld_out    = tok_ff;
   assign state_out = state_ff;

endmodule

@@ tb/circuit_short_and_continuity_check_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circuit_short_and_continuity_check_tb: self-checking bench of the board check
// Sends lists of board connections, predicts the error code of every list from
// its own copy of the edge store and the rail rows, and compares each response
// beat with the oldest predicted code. Both channels idle at random.
// ----------------------------------------------------------------------------
module circuit_short_and_continuity_check_tb;
   import scc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_WIRE    = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = KIND_W'(3);
   localparam int SETTLE_CYCLES = 4 * MAX_EDGES;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int PHASE_ITEMS   = 140;

   logic clock = 1'b0;
   logic reset;

   scc_req_if req_bus ();
   scc_rsp_if rsp_bus ();
   scc_csr_if csr_bus ();

   circuit_short_and_continuity_check dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // board model kept by the bench
   edge_type model_edges [MAX_EDGES];
   int model_count;
   logic [Y_W-1:0] model_supply_row;
   logic [Y_W-1:0] model_ground_row;

   logic [CODE_W-1:0] expected_codes [$];
   edge_type pending_list [$];
   int mismatch_count;
   int items_sent;
   int burst_left;

   function automatic logic blocks_short(logic [KIND_W-1:0] kind);
      return (kind == KIND_RESISTOR) || (kind == KIND_CAPACITOR);
   endfunction

   // breadth-first walk from the far ends of the supply seeds
   function automatic logic rails_joined(logic wires_only);
      hole_type frontier [$];
      logic visited [MAX_EDGES];
      hole_type far_hole;
      hole_type here;
      edge_type e;
      logic hit;
      int i;
      for (i = 0; i < MAX_EDGES; i++) visited[i] = 1'b0;
      for (i = 0; i < model_count; i++) begin
         e = model_edges[i];
         hit = 1'b1;
         if (e.a.y == model_supply_row) far_hole = e.b;
         else if (e.b.y == model_supply_row) far_hole = e.a;
         else hit = 1'b0;
         if (hit) begin
            visited[i] = 1'b1;
            // in the wires-only walk a resistor or capacitor seed is marked but not expanded
            if (!wires_only || !blocks_short(e.kind)) frontier.push_back(far_hole);
         end
      end
      while (frontier.size() > 0) begin
         here = frontier.pop_front();
         if (here.y == model_ground_row) return 1'b1;
         for (i = 0; i < model_count; i++) begin
            e = model_edges[i];
            hit = 1'b1;
            if (visited[i]) hit = 1'b0;
            else if (e.a == here) far_hole = e.b;
            else if (e.b == here) far_hole = e.a;
            else hit = 1'b0;
            if (hit && !(wires_only && blocks_short(e.kind))) begin
               visited[i] = 1'b1;
               frontier.push_back(far_hole);
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [CODE_W-1:0] list_error_code();
      logic seeded;
      int i;
      seeded = 1'b0;
      for (i = 0; i < model_count; i++)
         if (model_edges[i].a.y == model_supply_row || model_edges[i].b.y == model_supply_row)
            seeded = 1'b1;
      if (!seeded) return ERR_NO_SUPPLY;
      if (rails_joined(1'b1)) return ERR_SHORT;
      if (!rails_joined(1'b0)) return ERR_NO_CONDUCTION;
      return ERR_NONE;
   endfunction

   function automatic void store_edge_beat(edge_type e, logic last);
      logic repeated;
      int i;
      repeated = 1'b0;
      for (i = 0; i < model_count; i++)
         if (model_edges[i].a == e.a && model_edges[i].b == e.b) repeated = 1'b1;
      // store full: the beat is dropped, the check still runs
      if (!repeated && model_count < MAX_EDGES) begin
         model_edges[model_count] = e;
         model_count++;
      end
      if (last) begin
         expected_codes.push_back(list_error_code());
         model_count = 0;
      end
   endfunction

   function automatic edge_type mk_edge(int x1, int y1, int x2, int y2, logic [KIND_W-1:0] kind);
      edge_type e;
      e.a.x = X_W'(x1);
      e.a.y = Y_W'(y1);
      e.b.x = X_W'(x2);
      e.b.y = Y_W'(y2);
      e.kind = kind;
      return e;
   endfunction

   function automatic hole_type random_hole(logic [Y_W-1:0] row);
      hole_type h;
      h.y = row;
      h.x = ($urandom_range(0, 15) == 0) ? X_W'($urandom_range(30, 31))
                                         : X_W'($urandom_range(0, 29));
      return h;
   endfunction

   function automatic logic [KIND_W-1:0] random_kind();
      if ($urandom_range(0, 9) < 6) return KIND_WIRE;
      return KIND_W'($urandom_range(1, 3));
   endfunction

   function automatic void push_pending(hole_type p, hole_type q, logic [KIND_W-1:0] kind);
      edge_type e;
      if ($urandom_range(0, 1) == 1) begin
         e.a = p;
         e.b = q;
      end else begin
         e.a = q;
         e.b = p;
      end
      e.kind = kind;
      pending_list.push_back(e);
   endfunction

   // one request beat, with bursts and gaps on the sending side
   task automatic send_edge(input edge_type e, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_bus.valid     <= 1'b1;
      req_bus.end1_x    <= e.a.x;
      req_bus.end1_y    <= e.a.y;
      req_bus.end2_x    <= e.b.x;
      req_bus.end2_y    <= e.b.y;
      req_bus.part_kind <= e.kind;
      req_bus.last_edge <= last;
      do @(posedge clock); while (!req_bus.ready);
      store_edge_beat(e, last);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_pending_list();
      int i;
      for (i = 0; i < pending_list.size(); i++)
         send_edge(pending_list[i], i == pending_list.size() - 1);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_rows(input logic [Y_W-1:0] supply, input logic [Y_W-1:0] ground);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_SUPPLY_ROW;
      csr_bus.data  <= supply;
      do @(posedge clock); while (!csr_bus.ready);
      model_supply_row = supply;
      csr_bus.index <= CSR_GROUND_ROW;
      csr_bus.data  <= ground;
      do @(posedge clock); while (!csr_bus.ready);
      model_ground_row = ground;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic shuffle_pending();
      edge_type tmp;
      int i;
      int j;
      for (i = pending_list.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = pending_list[i];
         pending_list[i] = pending_list[j];
         pending_list[j] = tmp;
      end
   endtask

   // a path from supply to ground with branches, repeats and mixed parts
   task automatic build_circuit_list();
      hole_type path [$];
      edge_type copy;
      int depth;
      int extras;
      int k;
      pending_list.delete();
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      path.push_back(random_hole(model_supply_row));
      for (k = 1; k < depth; k++) path.push_back(random_hole(Y_W'($urandom_range(0, 15))));
      path.push_back(random_hole(model_ground_row));
      for (k = 0; k < depth; k++) push_pending(path[k], path[k + 1], random_kind());
      extras = $urandom_range(0, 5);
      for (k = 0; k < extras; k++) begin
         case ($urandom_range(0, 2))
            0: begin
               push_pending(path[$urandom_range(0, depth)],
                            random_hole(Y_W'($urandom_range(0, 15))), random_kind());
            end
            1: begin
               copy = pending_list[$urandom_range(0, pending_list.size() - 1)];
               copy.kind = random_kind();
               pending_list.push_back(copy);
            end
            default: begin
               push_pending(path[$urandom_range(0, depth)], path[$urandom_range(0, depth)],
                            random_kind());
            end
         endcase
      end
      shuffle_pending();
   endtask

   task automatic build_noise_list(input int count);
      edge_type e;
      int k;
      for (k = 0; k < count; k++) begin
         e.a.x  = X_W'($urandom_range(0, 31));
         e.a.y  = Y_W'($urandom_range(0, 15));
         e.b.x  = X_W'($urandom_range(0, 31));
         e.b.y  = Y_W'($urandom_range(0, 15));
         e.kind = KIND_W'($urandom_range(0, 3));
         pending_list.push_back(e);
      end
   endtask

   // few holes, so edges meet often and repeat
   task automatic build_pool_list(input int count);
      hole_type pool [5];
      int k;
      pending_list.delete();
      pool[0] = random_hole(model_supply_row);
      pool[1] = random_hole(model_ground_row);
      for (k = 2; k < 5; k++) pool[k] = random_hole(Y_W'($urandom_range(0, 15)));
      for (k = 0; k < count; k++)
         push_pending(pool[$urandom_range(0, 4)], pool[$urandom_range(0, 4)], random_kind());
   endtask

   task automatic build_random_list();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         build_circuit_list();
      end else if (pick < 75) begin
         pending_list.delete();
         build_noise_list($urandom_range(1, 8));
      end else if (pick < 98) begin
         build_pool_list($urandom_range(2, 12));
      end else begin
         // overfill the store; path edges past the limit get dropped
         build_circuit_list();
         build_noise_list($urandom_range(65, 72) - pending_list.size());
         shuffle_pending();
      end
   endtask

   task automatic test_basic_codes();
      send_edge(mk_edge(0, 1, 0, 12, KIND_WIRE), 1'b1);
      send_edge(mk_edge(3, 1, 3, 12, KIND_RESISTOR), 1'b1);
      send_edge(mk_edge(29, 12, 29, 1, KIND_CAPACITOR), 1'b1);
      send_edge(mk_edge(5, 1, 5, 12, KIND_UNKNOWN), 1'b1);
      send_edge(mk_edge(31, 15, 0, 0, KIND_WIRE), 1'b1);
   endtask

   task automatic test_paths_and_kinds();
      // holes differ, so no path
      send_edge(mk_edge(2, 1, 2, 5, KIND_WIRE), 1'b0);
      send_edge(mk_edge(7, 5, 7, 12, KIND_WIRE), 1'b1);
      // resistor seed followed by wires conducts but is no short
      send_edge(mk_edge(4, 1, 4, 6, KIND_RESISTOR), 1'b0);
      send_edge(mk_edge(4, 6, 9, 12, KIND_WIRE), 1'b1);
      // both ends on the supply row
      send_edge(mk_edge(10, 1, 11, 1, KIND_WIRE), 1'b0);
      send_edge(mk_edge(11, 1, 11, 12, KIND_CAPACITOR), 1'b1);
   endtask

   task automatic test_repeated_edges();
      send_edge(mk_edge(6, 1, 6, 7, KIND_RESISTOR), 1'b0);
      send_edge(mk_edge(6, 1, 6, 7, KIND_WIRE), 1'b0);
      send_edge(mk_edge(6, 7, 6, 12, KIND_WIRE), 1'b1);
      // reversed ends are a new edge
      send_edge(mk_edge(8, 1, 8, 7, KIND_RESISTOR), 1'b0);
      send_edge(mk_edge(8, 7, 8, 1, KIND_WIRE), 1'b0);
      send_edge(mk_edge(8, 7, 8, 12, KIND_WIRE), 1'b1);
   endtask

   task automatic test_out_of_range_holes();
      send_edge(mk_edge(31, 1, 30, 14, KIND_WIRE), 1'b0);
      send_edge(mk_edge(30, 14, 31, 15, KIND_WIRE), 1'b1);
   endtask

   task automatic test_row_registers();
      set_rows(Y_W'(0), Y_W'(13));
      send_edge(mk_edge(0, 0, 31, 13, KIND_WIRE), 1'b1);
      set_rows(Y_W'(13), Y_W'(0));
      send_edge(mk_edge(15, 13, 15, 0, KIND_CAPACITOR), 1'b1);
      // supply and ground on one row: a seed's far end decides
      set_rows(Y_W'(5), Y_W'(5));
      send_edge(mk_edge(1, 5, 2, 3, KIND_WIRE), 1'b1);
      set_rows(Y_W'(15), Y_W'(14));
      send_edge(mk_edge(31, 15, 31, 14, KIND_WIRE), 1'b1);
   endtask

   task automatic test_random_boards();
      logic [Y_W-1:0] row;
      int start;
      int phase_start;
      int phase;
      start = items_sent;
      phase = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         case (phase)
            0: set_rows(SUPPLY_ROW_RESET, GROUND_ROW_RESET);
            1: set_rows(Y_W'(0), Y_W'(13));
            2: set_rows(Y_W'(13), Y_W'(0));
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  row = Y_W'($urandom_range(0, 15));
                  set_rows(row, row);
               end else begin
                  set_rows(Y_W'($urandom_range(0, 13)), Y_W'($urandom_range(0, 13)));
               end
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent - start < RANDOM_ITEMS) begin
            build_random_list();
            send_pending_list();
         end
         phase++;
      end
   endtask

   // response side stalls in modes of random length
   int ready_mode;
   int mode_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (ready_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_codes.size() == 0) begin
            $error("error_code: expected none, actual %0d", rsp_bus.error_code);
            mismatch_count++;
         end else if (rsp_bus.error_code !== expected_codes[0]) begin
            $error("error_code: expected %0d, actual %0d", expected_codes[0],
                   rsp_bus.error_code);
            mismatch_count++;
            void'(expected_codes.pop_front());
         end else begin
            void'(expected_codes.pop_front());
         end
      end
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      items_sent = 0;
      burst_left = 0;
      model_count = 0;
      model_supply_row = SUPPLY_ROW_RESET;
      model_ground_row = GROUND_ROW_RESET;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.end1_x    <= '0;
      req_bus.end1_y    <= '0;
      req_bus.end2_x    <= '0;
      req_bus.end2_y    <= '0;
      req_bus.part_kind <= KIND_WIRE;
      req_bus.last_edge <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_SUPPLY_ROW;
      csr_bus.data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_basic_codes();
      test_paths_and_kinds();
      test_repeated_edges();
      test_out_of_range_holes();
      test_row_registers();
      test_random_boards();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/scc_pkg.sv
src/scc_if.sv
src/scc_cell.sv
src/circuit_short_and_continuity_check.sv
tb/circuit_short_and_continuity_check_tb.sv
